// ----- hw/rtl/multichannel_moving_sum_top_macros.svh -----
// Assertion helpers for the checker file mmsum_chk.sv.
`ifndef MULTICHANNEL_MOVING_SUM_TOP_MACROS_SVH
`define MULTICHANNEL_MOVING_SUM_TOP_MACROS_SVH

// Property checked while out of reset.
`define MMS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define MMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/mmsum_pkg.sv -----
`default_nettype none

package mmsum_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int SAMPLE_MAX  = 1023;
    localparam int CH_W        = 2;
    localparam int NUM_CH      = 4;
    localparam int WSUM_W      = 14;
    localparam int DEPTH_DEF   = 16;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CH_W-1:0] CH_FIRST = 2'd0;
    localparam logic [CH_W-1:0] CH_LAST  = 2'd3;

endpackage

`default_nettype wire

// ----- hw/rtl/multichannel_moving_sum_top.sv -----
// Four-channel moving sum for a round-robin scanned 10-bit converter.
// Slave stream: one conversion per transfer, sample in i_s_tdata[9:0],
//   channels arriving in the order 0,1,2,3,0,...
// Master stream: o_m_tuser = channel, o_m_tdata[13:0] = sum of that
//   channel's last DEPTH samples (empty slots count as zero).
// The first transfer after reset only starts the scan: it is dropped and
//   gives no result. Every later transfer gives exactly one result.
// Pipeline: the registered read of the sample ring, then the sum update
//   into the result register.
// Throughput: one sample per cycle, sustained while the receiver takes results.
// Reset (synchronous, active low) clears sums, slot valid bits, ring
//   position and both pipeline stages; no clearing pass is needed.
// Receiver stall: the result register holds, one further sample is still
//   taken into the ring-read stage if that stage is empty, then o_s_tready
//   drops until the result is taken.
`default_nettype none

module multichannel_moving_sum_top
    import mmsum_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_s_tvalid,
    output logic                    o_s_tready,
    input  wire  [IN_TDATA_W-1:0]   i_s_tdata,   // [9:0] sample
    output logic                    o_m_tvalid,
    input  wire                     i_m_tready,
    output logic [OUT_TDATA_W-1:0]  o_m_tdata,   // [13:0] window_sum
    output logic [CH_W-1:0]         o_m_tuser    // [1:0] channel
);

    localparam int POS_W     = $clog2(DEPTH);
    localparam int ADDR_W    = CH_W + POS_W;
    localparam int SLOTS     = NUM_CH << POS_W;
    localparam int SUM_RAW_W = $clog2(DEPTH * SAMPLE_MAX + 1);
    localparam int SUM_W     = (SUM_RAW_W > WSUM_W) ? SUM_RAW_W : WSUM_W;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(DEPTH - 1);

    logic                r_started;
    logic [CH_W-1:0]     r_ch;
    logic [POS_W-1:0]    r_pos;

    logic [SAMPLE_W-1:0] r_ring [SLOTS];
    logic [SLOTS-1:0]    r_slot_vld;
    logic [SUM_W-1:0]    r_sum [NUM_CH];

    logic                r_s1_vld;
    logic [CH_W-1:0]     r_s1_ch;
    logic [ADDR_W-1:0]   r_s1_addr;
    logic [SAMPLE_W-1:0] r_s1_sample;
    logic [SAMPLE_W-1:0] r_s1_old;
    logic                r_s1_old_vld;

    logic                r_out_vld;
    logic [CH_W-1:0]     r_out_ch;
    logic [WSUM_W-1:0]   r_out_sum;

    logic                adv;
    logic                s1_ready;
    logic                in_xfer;
    logic                wr;
    logic [ADDR_W-1:0]   rd_addr;
    logic [SAMPLE_W-1:0] old_eff;
    logic [SUM_W-1:0]    n_sum;

    assign adv      = !r_out_vld || i_m_tready;
    assign s1_ready = !r_s1_vld || adv;
    assign in_xfer  = i_s_tvalid && s1_ready;
    assign wr       = r_s1_vld && adv;
    assign rd_addr  = {r_ch, r_pos};

    assign old_eff  = r_s1_old_vld ? r_s1_old : '0;
    assign n_sum    = r_sum[r_s1_ch] - SUM_W'(old_eff) + SUM_W'(r_s1_sample);

    // sample ring
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_ring[r_s1_addr] <= r_s1_sample;
        end
        if (in_xfer) begin
            r_s1_old <= r_ring[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= 1'b0;
            r_ch       <= CH_FIRST;
            r_pos      <= '0;
            r_slot_vld <= '0;
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            for (int k = 0; k < NUM_CH; k++) begin
                r_sum[k] <= '0;
            end
        end else begin
            if (in_xfer) begin
                if (!r_started) begin
                    r_started <= 1'b1;
                end else begin
                    r_ch <= r_ch + CH_W'(1);
                    if (r_ch == CH_LAST) begin
                        r_pos <= (r_pos == POS_LAST) ? '0 : r_pos + POS_W'(1);
                    end
                end
            end
            if (s1_ready) begin
                r_s1_vld <= in_xfer && r_started;
            end
            if (adv) begin
                r_out_vld <= r_s1_vld;
            end
            if (wr) begin
                r_slot_vld[r_s1_addr] <= 1'b1;
                r_sum[r_s1_ch]        <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_ch      <= r_ch;
            r_s1_addr    <= rd_addr;
            r_s1_sample  <= i_s_tdata[SAMPLE_W-1:0];
            r_s1_old_vld <= r_slot_vld[rd_addr];
        end
        if (wr) begin
            r_out_ch  <= r_s1_ch;
            r_out_sum <= n_sum[WSUM_W-1:0];
        end
    end

    assign o_s_tready = s1_ready;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(OUT_TDATA_W - WSUM_W){1'b0}}, r_out_sum};
    assign o_m_tuser  = r_out_ch;

endmodule

`default_nettype wire

// ----- hw/rtl/mmsum_chk.sv -----
`default_nettype none

`include "multichannel_moving_sum_top_macros.svh"

module mmsum_chk
    import mmsum_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_s_tvalid,
    input  wire                     i_s_tready,
    input  wire                     i_m_tvalid,
    input  wire                     i_m_tready,
    input  wire  [OUT_TDATA_W-1:0]  i_m_tdata,
    input  wire  [CH_W-1:0]         i_m_tuser
);

    logic            r_started;
    logic [1:0]      r_pend;
    logic            r_seen;
    logic [CH_W-1:0] r_last_ch;
    logic            in_acc;
    logic            out_acc;

    assign in_acc  = i_s_tvalid && i_s_tready;
    assign out_acc = i_m_tvalid && i_m_tready;

    // results owed: transfers after the starting one, less results taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_pend    <= '0;
            r_seen    <= 1'b0;
            r_last_ch <= CH_FIRST;
        end else begin
            if (in_acc) begin
                r_started <= 1'b1;
            end
            r_pend <= r_pend + 2'(in_acc && r_started) - 2'(out_acc);
            if (out_acc) begin
                r_seen    <= 1'b1;
                r_last_ch <= i_m_tuser;
            end
        end
    end

    `MMS_ASSERT(a_stall_hold, i_clk, i_rst_n, (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser)), "result changed while stalled")
    `MMS_ASSERT(a_no_spurious, i_clk, i_rst_n, i_m_tvalid |-> (r_pend != 2'd0), "result without a matching sample")
    `MMS_ASSERT(a_first_ch, i_clk, i_rst_n, (out_acc && !r_seen) |-> (i_m_tuser == CH_FIRST), "first result not channel 0")
    `MMS_ASSERT(a_ch_order, i_clk, i_rst_n, (out_acc && r_seen) |-> (i_m_tuser == 2'(r_last_ch + 2'd1)), "channel order broken")
    `MMS_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !i_m_tvalid, "result valid after reset")

endmodule

bind multichannel_moving_sum_top mmsum_chk u_mmsum_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser)
);

`default_nettype wire
